[src/psieve_pkg.sv]
// Package for the prime sieve engine: number widths, controller states,
// and the command and status groups between controller and datapath.
// No dependencies.
`default_nettype none

package psieve_pkg;

	localparam int DATA_W  = 8;
	localparam int NUM_W   = 9;
	localparam int TDATA_W = 2 * DATA_W;
	localparam int SQ_W    = 2 * NUM_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_SV_RD,
		ST_SV_CHK,
		ST_STRIKE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic load;
		logic fill_wr;
		logic sieve_init;
		logic sv_rd;
		logic sieve_next;
		logic strike_init;
		logic strike_wr;
		logic scan_init;
		logic scan_rd;
		logic scan_take;
		logic flush_emit;
	} cmd_t;

	typedef struct packed {
		logic in_small;
		logic fill_done;
		logic sq_over;
		logic flag;
		logic strike_done;
		logic scan_end;
		logic out_free;
		logic pend_vld;
	} status_t;

endpackage

`default_nettype wire

[src/prime_sieve_engine_top.sv]
// Top level of the prime sieve engine: controller plus datapath.
// Depends on psieve_pkg, psieve_ctrl and psieve_dp.
//
//   channel | dir | tdata fields (lsb first)         | tlast
//   s_*     | in  | upper_bound[7:0]                 | -
//   m_*     | out | prime[7:0], largest_prime[15:8]  | is_last
//
// One request at a time. For bound n the engine sets the flag store, runs a
// sieve test for each p with p*p <= n, strikes each prime's multiples from
// p*p, then scans each candidate; the flag store has a single read/write
// port. Bounds below two produce no results. Reset clears control only; the
// flag store is rewritten by each request. A stalled output holds the scan;
// a new request is taken once the final result sits in the output register.
`default_nettype none

module prime_sieve_engine_top #(
	parameter int SIEVE_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] upper_bound
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] prime, [15:8] largest_prime
	output logic             m_tlast    // is_last
);
	import psieve_pkg::*;

	cmd_t    cmd;
	status_t status;
	state_t  state;

	psieve_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.cmd      (cmd),
		.state    (state)
	);

	psieve_dp #(
		.SIEVE_DEPTH (SIEVE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_bound  (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

	assign s_tready = cmd.in_ready;

`ifndef SYNTHESIS
	a_last_largest: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[15:8] == m_tdata[7:0])
		else $error("largest_prime differs from prime on final transaction");

	a_mid_largest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[15:8] == 8'd0)
		else $error("largest_prime nonzero before final transaction");

	a_prime_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:0] >= 8'd2)
		else $error("prime below two");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state == ST_IDLE && !status.pend_vld)
		else $error("request taken while a run is open");
`endif

endmodule

`default_nettype wire

[src/psieve_dp.sv]
// Datapath of the prime sieve engine: flag store, counters, square unit,
// pending prime and output register. Depends on psieve_pkg.
`default_nettype none

module psieve_dp #(
	parameter int SIEVE_DEPTH = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire psieve_pkg::cmd_t             cmd,
	output psieve_pkg::status_t               status,
	input  wire logic [psieve_pkg::DATA_W-1:0]  in_bound,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [psieve_pkg::TDATA_W-1:0]    out_data,
	output logic                              out_last
);
	import psieve_pkg::*;

	localparam int AW   = $clog2(SIEVE_DEPTH);
	localparam int BMAX = (SIEVE_DEPTH - 1 > 255) ? 255 : SIEVE_DEPTH - 1;

	logic                 flags_q [SIEVE_DEPTH];
	logic                 rd_data_q;
	logic [DATA_W-1:0]    bound_q;
	logic [NUM_W-1:0]     p_q;
	logic [NUM_W-1:0]     m_q;
	logic [SQ_W-1:0]      sq_q;
	logic [DATA_W-1:0]    pend_q;
	logic                 pend_vld_q;
	logic                 out_valid_q;
	logic [DATA_W-1:0]    out_prime_q;
	logic [DATA_W-1:0]    out_large_q;
	logic                 out_last_q;
	logic [DATA_W-1:0]    bound_sat;
	logic [NUM_W:0]       m_step;
	logic                 wr_en;
	logic                 rd_en;
	logic                 load_out;

	assign bound_sat = (in_bound > DATA_W'(BMAX)) ? DATA_W'(BMAX) : in_bound;
	assign m_step    = {1'b0, m_q} + {1'b0, p_q};
	assign wr_en     = cmd.fill_wr | cmd.strike_wr;
	assign rd_en     = cmd.sv_rd | cmd.scan_rd;
	assign load_out  = (cmd.scan_take & rd_data_q & pend_vld_q) | cmd.flush_emit;

	always_comb begin
		status.in_small    = (bound_sat < DATA_W'(2));
		status.fill_done   = (m_q == {1'b0, bound_q});
		status.sq_over     = (sq_q > SQ_W'(bound_q));
		status.flag        = rd_data_q;
		status.strike_done = (m_step > (NUM_W + 1)'(bound_q));
		status.scan_end    = (p_q == {1'b0, bound_q});
		status.out_free    = ~out_valid_q | out_ready;
		status.pend_vld    = pend_vld_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			flags_q[AW'(m_q)] <= cmd.fill_wr;
		end
		if (rd_en) begin
			rd_data_q <= flags_q[AW'(p_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bound_q <= bound_sat;
			m_q     <= NUM_W'(2);
		end else if (cmd.fill_wr) begin
			m_q <= m_q + NUM_W'(1);
		end else if (cmd.strike_init) begin
			m_q <= sq_q[NUM_W-1:0];
		end else if (cmd.strike_wr) begin
			m_q <= m_step[NUM_W-1:0];
		end
		if (cmd.sieve_init || cmd.scan_init) begin
			p_q <= NUM_W'(2);
		end else if (cmd.sieve_next || cmd.scan_take) begin
			p_q <= p_q + NUM_W'(1);
		end
		if (cmd.sv_rd) begin
			sq_q <= p_q * p_q;
		end
		if (cmd.scan_take && rd_data_q) begin
			pend_q <= p_q[DATA_W-1:0];
		end
		if (load_out) begin
			out_prime_q <= pend_q;
			out_last_q  <= cmd.flush_emit;
			out_large_q <= cmd.flush_emit ? pend_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_init || cmd.flush_emit) begin
				pend_vld_q <= 1'b0;
			end else if (cmd.scan_take && rd_data_q) begin
				pend_vld_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {out_large_q, out_prime_q};
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

[src/psieve_ctrl.sv]
// Controller of the prime sieve engine: sequences fill, sieve, strike, scan
// and flush phases over the datapath. Depends on psieve_pkg.
`default_nettype none

module psieve_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire psieve_pkg::status_t status,
	output psieve_pkg::cmd_t         cmd,
	output psieve_pkg::state_t       state
);
	import psieve_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   scan_stall;

	assign scan_stall = status.flag & status.pend_vld & ~status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !status.in_small) state_d = ST_FILL;
			end
			ST_FILL: begin
				if (status.fill_done) state_d = ST_SV_RD;
			end
			ST_SV_RD: state_d = ST_SV_CHK;
			ST_SV_CHK: begin
				priority if (status.sq_over) state_d = ST_SCAN_RD;
				else if (status.flag) state_d = ST_STRIKE;
				else state_d = ST_SV_RD;
			end
			ST_STRIKE: begin
				if (status.strike_done) state_d = ST_SV_RD;
			end
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (!scan_stall) state_d = status.scan_end ? ST_FLUSH : ST_SCAN_RD;
			end
			ST_FLUSH: begin
				if (!status.pend_vld || status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = in_valid;
			end
			ST_FILL: begin
				cmd.fill_wr    = 1'b1;
				cmd.sieve_init = status.fill_done;
			end
			ST_SV_RD: cmd.sv_rd = 1'b1;
			ST_SV_CHK: begin
				priority if (status.sq_over) cmd.scan_init = 1'b1;
				else if (status.flag) cmd.strike_init = 1'b1;
				else cmd.sieve_next = 1'b1;
			end
			ST_STRIKE: begin
				cmd.strike_wr  = 1'b1;
				cmd.sieve_next = status.strike_done;
			end
			ST_SCAN_RD: cmd.scan_rd = 1'b1;
			ST_SCAN_CHK: cmd.scan_take = ~scan_stall;
			ST_FLUSH: cmd.flush_emit = status.pend_vld & status.out_free;
			default: cmd = '0;
		endcase
	end

	assign state = state_q;

endmodule

`default_nettype wire
